### rtl/core/tlbp_pkg.sv
// ----------------------------------------------------------------------------
// tlbp_pkg
// Shared constants, codes and counter update rule for the branch predictor.
// ----------------------------------------------------------------------------
package tlbp_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PC_INDEX_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_BITS  = 2'd1;

	// register widths and reset values
	localparam int PCB_W = 4;
	localparam int HB_W  = 3;
	localparam logic [PCB_W-1:0] PCB_RST = 4'd8;
	localparam logic [HB_W-1:0]  HB_RST  = 3'd4;

	// decoupling queue depth, power of two
	localparam int Q_DEPTH = 2;

	// 2-bit counter codes
	localparam logic [1:0] CTR_STRONG_T = 2'd3;
	localparam logic [1:0] CTR_WEAK_T   = 2'd2;
	localparam logic [1:0] CTR_WEAK_N   = 2'd1;
	localparam logic [1:0] CTR_STRONG_N = 2'd0;
	localparam logic [1:0] CTR_INIT     = CTR_STRONG_T;

	// hysteresis update rule
	function automatic logic [1:0] next_counter(input logic [1:0] c, input logic taken);
		logic [1:0] n;
		case (c)
			CTR_STRONG_T: n = taken ? CTR_STRONG_T : CTR_WEAK_T;
			CTR_WEAK_T:   n = taken ? CTR_STRONG_T : CTR_STRONG_N;
			CTR_WEAK_N:   n = taken ? CTR_STRONG_T : CTR_STRONG_N;
			default:      n = taken ? CTR_WEAK_N : CTR_STRONG_N;
		endcase
		return n;
	endfunction

endpackage

### rtl/core/tlbp_front.sv
// ----------------------------------------------------------------------------
// tlbp_front
// Accepts resolved branches, forms the table index from address and global
// history, advances the history and holds the configuration registers.
// ----------------------------------------------------------------------------
module tlbp_front import tlbp_pkg::*; #(
	parameter int MAX_PC_INDEX_BITS = 8,
	parameter int MAX_HISTORY_BITS  = 4
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic [31:0]                                 branch_pc,
	input  logic                                        outcome_taken,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]                        cfg_index,
	input  logic [CFG_DATA_W-1:0]                       cfg_data,
	input  logic                                        table_ready,
	input  logic                                        q_full,
	output logic                                        q_push,
	output logic [MAX_PC_INDEX_BITS+MAX_HISTORY_BITS-1:0] q_idx,
	output logic                                        q_taken
);

	localparam int MW = $clog2(MAX_PC_INDEX_BITS + 1);
	localparam int KW = $clog2(MAX_HISTORY_BITS + 1);

	logic [PCB_W-1:0]            pcb_q;
	logic [HB_W-1:0]             hb_q;
	logic [MAX_HISTORY_BITS-1:0] hist_q;
	logic [MW-1:0]               m_eff;
	logic [KW-1:0]               k_eff;
	logic [MAX_PC_INDEX_BITS-1:0] row;
	logic [MAX_HISTORY_BITS-1:0] col;
	logic [MAX_HISTORY_BITS-1:0] col_sh;
	logic [MAX_HISTORY_BITS-1:0] hist_nxt;

	assign cfg_ready = 1'b1;
	assign in_ready  = table_ready & ~q_full;
	assign q_push    = in_valid & in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcb_q <= PCB_RST;
			hb_q  <= HB_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_PC_INDEX_BITS) begin
				pcb_q <= cfg_data[PCB_W-1:0];
			end else if (cfg_index == CFG_HISTORY_BITS) begin
				hb_q <= cfg_data[HB_W-1:0];
			end
		end
	end

	// saturate widths at their maximum
	assign m_eff = (int'(pcb_q) > MAX_PC_INDEX_BITS) ? MW'(MAX_PC_INDEX_BITS) : MW'(pcb_q);
	assign k_eff = (int'(hb_q) > MAX_HISTORY_BITS) ? KW'(MAX_HISTORY_BITS) : KW'(hb_q);

	// row and column selection
	always_comb begin
		for (int i = 0; i < MAX_PC_INDEX_BITS; i++) begin
			row[i] = branch_pc[i] & (i < int'(m_eff));
		end
		for (int j = 0; j < MAX_HISTORY_BITS; j++) begin
			col[j] = hist_q[j] & (j < int'(k_eff));
		end
	end

	assign q_idx   = {row, col};
	assign q_taken = outcome_taken;
	assign col_sh  = col >> 1;

	// outcome enters at the top of the active history
	always_comb begin
		for (int j = 0; j < MAX_HISTORY_BITS; j++) begin
			if (j == int'(k_eff) - 1) begin
				hist_nxt[j] = outcome_taken;
			end else if (j < int'(k_eff) - 1) begin
				hist_nxt[j] = col_sh[j];
			end else begin
				hist_nxt[j] = 1'b0;
			end
		end
	end

	// global history register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '1;
		end else if (q_push && k_eff != '0) begin
			hist_q <= hist_nxt;
		end
	end

endmodule

### rtl/core/tlbp_queue.sv
// ----------------------------------------------------------------------------
// tlbp_queue
// Small request queue between the index front and the table back.
// ----------------------------------------------------------------------------
module tlbp_queue import tlbp_pkg::*; #(
	parameter int W = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         nempty,
	output logic [W-1:0] rdata
);

	localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	logic [W-1:0]  slot_q [Q_DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   cnt_q;

	assign full   = (cnt_q == (AW+1)'(Q_DEPTH));
	assign nempty = (cnt_q != '0);
	assign rdata  = slot_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!nempty |-> !pop) else $error("queue pop while empty");
`endif

endmodule

### rtl/core/tlbp_back.sv
// ----------------------------------------------------------------------------
// tlbp_back
// Counter table: read, predict, hysteresis update and write back, with the
// result register and the clearing pass after reset.
// ----------------------------------------------------------------------------
module tlbp_back import tlbp_pkg::*; #(
	parameter int IW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nempty,
	input  logic [IW-1:0] q_idx,
	input  logic          q_taken,
	output logic          q_pop,
	output logic          table_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          predict_taken
);

	logic [1:0]    mem [2**IW];
	logic          clearing_q;
	logic [IW-1:0] clr_cnt_q;
	logic          valid_s1;
	logic [IW-1:0] idx_s1;
	logic          taken_s1;
	logic [1:0]    rd_s1;
	logic          wr_vld_q;
	logic [IW-1:0] wr_idx_q;
	logic [1:0]    wr_val_q;
	logic          out_valid_q;
	logic          predict_q;
	logic          adv;
	logic [1:0]    cur;
	logic [1:0]    nxt;
	logic          we;
	logic [IW-1:0] waddr;
	logic [1:0]    wdata;

	assign table_ready   = ~clearing_q;
	assign out_valid     = out_valid_q;
	assign predict_taken = predict_q;

	// stage control
	assign adv   = valid_s1 & (~out_valid_q | out_ready);
	assign q_pop = q_nempty & ~clearing_q & (~valid_s1 | adv);

	// forward the write that raced this entry's read
	assign cur = (wr_vld_q && wr_idx_q == idx_s1) ? wr_val_q : rd_s1;
	assign nxt = next_counter(cur, taken_s1);

	// single write port, shared with the clearing pass
	assign we    = clearing_q | adv;
	assign waddr = clearing_q ? clr_cnt_q : idx_s1;
	assign wdata = clearing_q ? CTR_INIT : nxt;

	// counter table
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (q_pop) begin
			rd_s1 <= mem[q_idx];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			idx_s1   <= q_idx;
			taken_s1 <= q_taken;
		end
		if (adv) begin
			wr_idx_q  <= idx_s1;
			wr_val_q  <= nxt;
			predict_q <= cur[1];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_cnt_q   <= '0;
			valid_s1    <= 1'b0;
			wr_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				wr_vld_q <= 1'b1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !q_pop && !valid_s1) else $error("table read during clearing");
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q && wr_vld_q) else $error("advanced request left no result");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(predict_q))
		else $error("waiting result changed");
`endif

endmodule

### rtl/core/two_level_branch_predictor_unit.sv
// Accept to result valid: queue slot, table read, result register; the counter
// update is written back as the result register loads. Throughput: one branch
// per cycle while out_ready is high, bound by the single read and write port
// pair of the counter table, with write forwarding between neighboring requests.
// Reset: the history goes to all ones and the configuration to 8 and 4 at once;
// a clearing pass then writes 3, with in_ready low, one a cycle, into all the
// 2**(MAX_PC_INDEX_BITS+MAX_HISTORY_BITS) counters (4096 by default).
// ----------------------------------------------------------------------------
// two_level_branch_predictor_unit
// Global-history two-level branch predictor with 2-bit hysteresis counters.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_unit import tlbp_pkg::*; #(
	parameter int MAX_PC_INDEX_BITS = 8,
	parameter int MAX_HISTORY_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [31:0]           branch_pc,
	input  logic                  outcome_taken,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  predict_taken,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = MAX_PC_INDEX_BITS + MAX_HISTORY_BITS;

	logic          table_ready;
	logic          q_full;
	logic          q_push;
	logic [IW-1:0] f_idx;
	logic          f_taken;
	logic          q_pop;
	logic          q_nempty;
	logic [IW:0]   q_rdata;

	// index front
	tlbp_front #(
		.MAX_PC_INDEX_BITS(MAX_PC_INDEX_BITS),
		.MAX_HISTORY_BITS (MAX_HISTORY_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.branch_pc    (branch_pc),
		.outcome_taken(outcome_taken),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.table_ready  (table_ready),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_idx        (f_idx),
		.q_taken      (f_taken)
	);

	// request queue
	tlbp_queue #(
		.W(IW + 1)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({f_taken, f_idx}),
		.full  (q_full),
		.pop   (q_pop),
		.nempty(q_nempty),
		.rdata (q_rdata)
	);

	// counter table back
	tlbp_back #(
		.IW(IW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nempty     (q_nempty),
		.q_idx        (q_rdata[IW-1:0]),
		.q_taken      (q_rdata[IW]),
		.q_pop        (q_pop),
		.table_ready  (table_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.predict_taken(predict_taken)
	);

endmodule

### test/branch_predict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// branch_predict_checker
// Watches the branch, result and register write channels of the predictor.
// Keeps its own counter table, global history and register copies, works out
// the prediction for every accepted branch and compares it with the returned
// result in order. Reports mismatches and results that arrive with none due.
// ----------------------------------------------------------------------------
module branch_predict_checker import tlbp_pkg::*; #(
	parameter int MAX_PC_INDEX_BITS = 8,
	parameter int MAX_HISTORY_BITS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [31:0]           branch_pc,
	input  logic                  outcome_taken,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  predict_taken,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int SLOTS = 1 << (MAX_PC_INDEX_BITS + MAX_HISTORY_BITS);

	logic [1:0]                  ctr_tbl [SLOTS];
	logic [MAX_HISTORY_BITS-1:0] ghist;
	logic [PCB_W-1:0]            row_bits_cfg;
	logic [HB_W-1:0]             hist_bits_cfg;
	logic                        due_predictions [$];
	int                          errs;

	// read the counter, train it, shift the outcome into the history
	function automatic logic predict_and_train(input logic [31:0] pc, input logic taken);
		int unsigned rbits, hbits, row, col, slot, tk;
		logic [1:0] c;
		logic [MAX_HISTORY_BITS-1:0] hmask;
		rbits = (row_bits_cfg > MAX_PC_INDEX_BITS) ? MAX_PC_INDEX_BITS : row_bits_cfg;
		hbits = (hist_bits_cfg > MAX_HISTORY_BITS) ? MAX_HISTORY_BITS : hist_bits_cfg;
		tk = taken;
		row = pc & ((32'd1 << rbits) - 32'd1);
		hmask = MAX_HISTORY_BITS'((32'd1 << hbits) - 32'd1);
		col = ghist & hmask;
		slot = (row << MAX_HISTORY_BITS) | col;
		c = ctr_tbl[slot];
		// taken jumps to strong taken except from strong not taken,
		// not taken drops to strong not taken except from strong taken
		if (taken) begin
			ctr_tbl[slot] = (c == CTR_STRONG_N) ? CTR_WEAK_N : CTR_STRONG_T;
		end else begin
			ctr_tbl[slot] = (c == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_N;
		end
		// a zero history width leaves the history alone
		if (hbits != 0) begin
			ghist = MAX_HISTORY_BITS'(((col >> 1) | (tk << (hbits - 1))) & hmask);
		end
		return c[1];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				ctr_tbl[i] = CTR_INIT;
			end
			ghist = '1;
			row_bits_cfg = PCB_RST;
			hist_bits_cfg = HB_RST;
			due_predictions.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// register write, unknown indexes ignored
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PC_INDEX_BITS) begin
					row_bits_cfg = cfg_data[PCB_W-1:0];
				end else if (cfg_index == CFG_HISTORY_BITS) begin
					hist_bits_cfg = cfg_data[HB_W-1:0];
				end
			end
			// returned prediction against the oldest one due
			if (out_valid && out_ready) begin
				if (due_predictions.size() == 0) begin
					$display("%0t: unexpected predict_taken, expected none, actual %0b",
						$time, predict_taken);
					errs++;
				end else begin
					want = due_predictions.pop_front();
					if (predict_taken !== want) begin
						$display("%0t: predict_taken mismatch, expected %0b, actual %0b",
							$time, want, predict_taken);
						errs++;
					end
				end
			end
			// accepted branch request
			if (in_valid && in_ready) begin
				due_predictions = {due_predictions,
					predict_and_train(branch_pc, outcome_taken)};
			end
			fail_count <= errs;
			pending <= due_predictions.size();
		end
	end

endmodule

### test/tb_two_level_branch_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_branch_predictor_unit
// Drives resolved branches and register writes into the predictor: a directed
// opening (address extremes, every counter transition, saturated and zero
// widths, ignored register indexes) then random loop-like branch streams over
// many register settings, under changing sender and receiver stall rates.
// The checker beside the block predicts and compares; this module judges.
// ----------------------------------------------------------------------------
module tb_two_level_branch_predictor_unit;
	import tlbp_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int N_BLOCKS        = 11;
	localparam int ITEMS_PER_BLOCK = 150;
	localparam int POOL            = 8;

	// register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [31:0]           branch_pc;
	logic                  outcome_taken;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  predict_taken;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int send_idle;
	int recv_idle;
	int cycles = 0;

	// register settings for the random blocks, extremes included
	logic [CFG_DATA_W-1:0] row_plan  [N_BLOCKS] = '{8, 0, 15, 1, 8, 3, 12, 5, 8, 0, 6};
	logic [CFG_DATA_W-1:0] hist_plan [N_BLOCKS] = '{4, 0, 15, 1, 2, 4, 3, 6, 0, 4, 5};

	// branch pool standing in for a handful of loops
	logic [31:0] pool_pc   [POOL];
	int          pool_len  [POOL];
	int          pool_iter [POOL];

	two_level_branch_predictor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.branch_pc     (branch_pc),
		.outcome_taken (outcome_taken),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.predict_taken (predict_taken),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	branch_predict_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.branch_pc     (branch_pc),
		.outcome_taken (outcome_taken),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.predict_taken (predict_taken),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one branch request, with random idle cycles ahead of it
	task automatic send_branch(input logic [31:0] pc, input logic taken);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		branch_pc <= pc;
		outcome_taken <= taken;
		do @(posedge clk); while (!in_ready);
	endtask

	// one register write request, valid left high for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// stop sending and let every due prediction come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] row_bits,
			input logic [CFG_DATA_W-1:0] hist_bits, input bit junk);
		wait_idle();
		if (junk) begin
			write_reg(CFG_UNUSED_A, CFG_DATA_W'($urandom));
			write_reg(CFG_UNUSED_B, CFG_DATA_W'($urandom));
		end
		write_reg(CFG_PC_INDEX_BITS, row_bits);
		write_reg(CFG_HISTORY_BITS, hist_bits);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int a;
		logic walk [12];
		in_valid = 1'b0;
		branch_pc = '0;
		outcome_taken = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle = 27;
		recv_idle = 82;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// address extremes at reset widths
		send_branch(32'h0000_0000, 1'b0);
		send_branch(32'hFFFF_FFFF, 1'b1);
		send_branch(32'h8000_0000, 1'b1);
		send_branch(32'h0000_00FF, 1'b0);

		// zero row and history bits: one counter walks every transition
		apply_settings(4'd0, 4'd0, 1'b0);
		walk = '{0, 0, 0, 1, 0, 1, 1, 1, 0, 1, 0, 0};
		foreach (walk[i]) begin
			send_branch($urandom, walk[i]);
		end

		// widths above their maximum saturate
		apply_settings(4'd15, 4'hF, 1'b0);
		send_branch(32'h0000_00FF, 1'b1);
		send_branch(32'hFFFF_FF00, 1'b0);
		send_branch($urandom, 1'b1);
		send_branch($urandom, 1'b0);

		// ignored indexes, then a narrower history
		apply_settings(4'd8, 4'd2, 1'b1);
		repeat (4) send_branch($urandom, 1'($urandom_range(1)));

		// random loop streams over several settings and stall mixes
		for (int b = 0; b < N_BLOCKS; b++) begin
			if (b < 4) begin
				send_idle = 27;
				recv_idle = 82;
			end else if (b < 8) begin
				send_idle = 82;
				recv_idle = 27;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			apply_settings(row_plan[b], hist_plan[b], b % 2 == 1);
			for (int p = 0; p < POOL; p++) begin
				pool_pc[p] = $urandom;
				pool_len[p] = $urandom_range(2, 7);
				pool_iter[p] = 0;
			end
			for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
				if ($urandom_range(99) < 70) begin
					a = $urandom_range(POOL - 1);
					pool_iter[a]++;
					send_branch(pool_pc[a], (pool_iter[a] % pool_len[a]) != 0);
				end else begin
					send_branch($urandom, 1'($urandom_range(1)));
				end
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### two_level_branch_predictor_unit.f
rtl/core/tlbp_pkg.sv
rtl/core/tlbp_front.sv
rtl/core/tlbp_queue.sv
rtl/core/tlbp_back.sv
rtl/core/two_level_branch_predictor_unit.sv
test/branch_predict_checker.sv
test/tb_two_level_branch_predictor_unit.sv
